// File: src/tbps_pkg.sv
// Package for the token bucket packet shaper: operation and event codes,
// field widths, the register map and the queue entry type. No dependencies.
package tbps_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 16;
    localparam int TOK_W     = 10;
    localparam int EV_W      = 3;
    localparam int CNT_OUT_W = 7;
    localparam int PADDR_W   = 3;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic [EV_W-1:0] EV_TOKEN_ADDED   = 3'd0;
    localparam logic [EV_W-1:0] EV_TOKEN_DROPPED = 3'd1;
    localparam logic [EV_W-1:0] EV_TOO_LARGE     = 3'd2;
    localparam logic [EV_W-1:0] EV_QUEUE_FULL    = 3'd3;
    localparam logic [EV_W-1:0] EV_QUEUED        = 3'd4;
    localparam logic [EV_W-1:0] EV_FLUSHED       = 3'd5;

    localparam logic [PADDR_W-1:0] ADDR_BUCKET_DEPTH = 3'd0;
    localparam logic [TOK_W-1:0]   BUCKET_DEPTH_RST  = 10'd10;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TOK_W-1:0] need;
    } entry_t;

endpackage

// File: src/token_bucket_packet_shaper.sv
// Token bucket packet shaper: bucket counter, holding FIFO in an inferred
// memory with a prefetched head, and the register port. Uses tbps_pkg.
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  input     in_valid / in_ready        op, packet_id, tokens_needed
//  output    out_valid / out_ready      event_res, released, released_id,
//                                       tokens_now, queue_count, removed_count
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A beat is registered on acceptance and its result goes to the result register
// when the beat moves on: one beat per cycle sustained unless the output stalls.
// The head of the FIFO is reread from the memory every cycle at the next head
// address, with a bypass for an entry written in the same cycle.
// A stalled output holds the input register; the input side stays ready while
// the input register is empty or moving on. Reset empties the FIFO and the bucket.
module token_bucket_packet_shaper #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tbps_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tbps_pkg::OP_W-1:0]          op,
    input  logic [tbps_pkg::ID_W-1:0]          packet_id,
    input  logic [tbps_pkg::TOK_W-1:0]         tokens_needed,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tbps_pkg::EV_W-1:0]          event_res,
    output logic                               released,
    output logic [tbps_pkg::ID_W-1:0]          released_id,
    output logic [tbps_pkg::TOK_W-1:0]         tokens_now,
    output logic [tbps_pkg::CNT_OUT_W-1:0]     queue_count,
    output logic [tbps_pkg::CNT_OUT_W-1:0]     removed_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC  = OW'(QUEUE_DEPTH);

    // Configuration register.
    logic [tbps_pkg::TOK_W-1:0] depth_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == tbps_pkg::ADDR_BUCKET_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= tbps_pkg::BUCKET_DEPTH_RST;
        end
        else if (cfg_wr)
        begin
            depth_reg <= pwdata[tbps_pkg::TOK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == tbps_pkg::ADDR_BUCKET_DEPTH)
        begin
            prdata = {{(32 - tbps_pkg::TOK_W){1'b0}}, depth_reg};
        end
    end

    // Input register.
    logic                       in_v_reg;
    logic [tbps_pkg::OP_W-1:0]  op_reg;
    logic [tbps_pkg::ID_W-1:0]  id_reg;
    logic [tbps_pkg::TOK_W-1:0] need_reg;
    logic                       out_v_reg;
    logic                       advance;

    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            id_reg   <= packet_id;
            need_reg <= tokens_needed;
        end
    end

    // Bucket and queue state.
    logic [tbps_pkg::TOK_W-1:0] tok_reg;
    logic [AW-1:0]              head_reg;
    logic [AW-1:0]              tail_reg;
    logic [OW-1:0]              occ_reg;

    tbps_pkg::entry_t           mem [QUEUE_DEPTH];
    tbps_pkg::entry_t           rd_reg;
    tbps_pkg::entry_t           byp_reg;
    logic                       byp_v_reg;

    // Step logic.
    logic                       is_flush;
    logic                       is_tick;
    logic                       queued;
    logic [tbps_pkg::EV_W-1:0]  ev;
    logic [tbps_pkg::TOK_W-1:0] tok_mid;
    logic [OW-1:0]              occ_mid;
    tbps_pkg::entry_t           new_entry;
    tbps_pkg::entry_t           head_entry;
    logic                       rel;
    logic [tbps_pkg::TOK_W-1:0] tok_next;
    logic [AW-1:0]              head_next;
    logic [AW-1:0]              tail_next;
    logic [OW-1:0]              occ_next;
    logic                       wr_en;

    // Op codes with the high bit set, the unused one included, flush the queue.
    assign is_flush = op_reg[1];
    assign is_tick  = (op_reg == tbps_pkg::OP_TICK);

    assign new_entry.id   = id_reg;
    assign new_entry.need = need_reg;

    always_comb
    begin
        ev      = tbps_pkg::EV_FLUSHED;
        tok_mid = tok_reg;
        occ_mid = occ_reg;
        queued  = 1'b0;
        priority if (is_flush)
        begin
            ev      = tbps_pkg::EV_FLUSHED;
            occ_mid = '0;
        end
        else if (is_tick)
        begin
            if (tok_reg >= depth_reg)
            begin
                ev = tbps_pkg::EV_TOKEN_DROPPED;
            end
            else
            begin
                ev      = tbps_pkg::EV_TOKEN_ADDED;
                tok_mid = tok_reg + 1'b1;
            end
        end
        else
        begin
            priority if (need_reg > depth_reg)
            begin
                ev = tbps_pkg::EV_TOO_LARGE;
            end
            else if (occ_reg >= FULL_OCC)
            begin
                ev = tbps_pkg::EV_QUEUE_FULL;
            end
            else
            begin
                ev      = tbps_pkg::EV_QUEUED;
                queued  = 1'b1;
                occ_mid = occ_reg + 1'b1;
            end
        end
    end

    // A packet queued into an empty FIFO is its own head.
    always_comb
    begin
        if (occ_reg == '0)
        begin
            head_entry = new_entry;
        end
        else if (byp_v_reg)
        begin
            head_entry = byp_reg;
        end
        else
        begin
            head_entry = rd_reg;
        end
    end

    assign rel   = !is_flush && (occ_mid != '0) && (head_entry.need <= tok_mid);
    assign wr_en = advance && queued;

    always_comb
    begin
        tok_next  = tok_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (advance)
        begin
            tok_next = rel ? (tok_mid - head_entry.need) : tok_mid;
            occ_next = rel ? (occ_mid - 1'b1) : occ_mid;
            if (is_flush)
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                if (queued)
                begin
                    tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                end
                if (rel)
                begin
                    head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            byp_v_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            byp_v_reg <= wr_en && (tail_reg == head_next);
        end
    end

    // The memory is read every cycle at the head address that the next step sees.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= new_entry;
        end
        rd_reg  <= mem[head_next];
        byp_reg <= new_entry;
    end

    // Result register.
    logic [tbps_pkg::EV_W-1:0]  ev_reg;
    logic                       rel_reg;
    logic [tbps_pkg::ID_W-1:0]  rel_id_reg;
    logic [tbps_pkg::TOK_W-1:0] tok_out_reg;
    logic [OW-1:0]              occ_out_reg;
    logic [OW-1:0]              removed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg      <= ev;
            rel_reg     <= rel;
            rel_id_reg  <= rel ? head_entry.id : '0;
            tok_out_reg <= tok_next;
            occ_out_reg <= occ_next;
            removed_reg <= is_flush ? occ_reg : '0;
        end
    end

    assign out_valid     = out_v_reg;
    assign event_res     = ev_reg;
    assign released      = rel_reg;
    assign released_id   = rel_id_reg;
    assign tokens_now    = tok_out_reg;
    assign queue_count   = tbps_pkg::CNT_OUT_W'(occ_out_reg);
    assign removed_count = tbps_pkg::CNT_OUT_W'(removed_reg);

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_OCC)
        else $error("queue occupancy above its depth");

    a_flush_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && (ev_reg == tbps_pkg::EV_FLUSHED) |-> !rel_reg && (occ_out_reg == '0))
        else $error("flush result shows a release or a non-empty queue");

    a_no_release_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !rel_reg |-> (rel_id_reg == '0))
        else $error("released id set without a release");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> in_ready)
        else $error("input stalled while the result register is free");

    a_release_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rel |=> (head_reg != $past(head_reg)) || (QUEUE_DEPTH == 1))
        else $error("release did not advance the head pointer");
`endif

endmodule

// File: test/token_bucket_packet_shaper_test.sv
// Self-checking testbench for token_bucket_packet_shaper: directed table, then random phases
// over several bucket depths, each result checked against an in-bench bucket and queue model
// or, for typed table rows, against the row. Depends on tbps_pkg and the shaper RTL only.
`timescale 1ns / 100ps

module token_bucket_packet_shaper_test;

    localparam int QUEUE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam logic [tbps_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [tbps_pkg::EV_W-1:0]      ev;
        logic                           rel;
        logic [tbps_pkg::ID_W-1:0]      rel_id;
        logic [tbps_pkg::TOK_W-1:0]     tokens;
        logic [tbps_pkg::CNT_OUT_W-1:0] qcount;
        logic [tbps_pkg::CNT_OUT_W-1:0] removed;
    } shaper_res_t;

    typedef enum logic [0:0] {ROW_BEAT, ROW_CFG} row_kind_t;

    // For a ROW_CFG row the need field carries the new bucket depth.
    typedef struct packed {
        row_kind_t                  kind;
        logic [tbps_pkg::OP_W-1:0]  op;
        logic [tbps_pkg::ID_W-1:0]  id;
        logic [tbps_pkg::TOK_W-1:0] need;
        logic                       typed;
        shaper_res_t                res;
    } step_row_t;

    localparam step_row_t DIRECTED_STEPS [24] = '{
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b1,
          '{tbps_pkg::EV_TOKEN_ADDED, 1'b0, 16'h0000, 10'd1, 7'd0, 7'd0}},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'hFFFF, 10'd0,    1'b1,
          '{tbps_pkg::EV_QUEUED,      1'b1, 16'hFFFF, 10'd1, 7'd0, 7'd0}},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h0000, 10'd1023, 1'b1,
          '{tbps_pkg::EV_TOO_LARGE,   1'b0, 16'h0000, 10'd1, 7'd0, 7'd0}},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h1234, 10'd3,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h5678, 10'd10,   1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'hFFFF, 10'd1023, 1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_FLUSH,  16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, OP_SPARE,            16'h0000, 10'd0,    1'b0, '0},
        '{ROW_CFG,  tbps_pkg::OP_TICK,   16'h0000, 10'd1023, 1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h8000, 10'd1023, 1'b0, '0},
        '{ROW_CFG,  tbps_pkg::OP_TICK,   16'h0000, 10'd1,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'hAAAA, 10'd2,    1'b0, '0},
        '{ROW_CFG,  tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_TICK,   16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h0001, 10'd1,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h5555, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_FLUSH,  16'h0000, 10'd0,    1'b0, '0},
        '{ROW_BEAT, tbps_pkg::OP_ARRIVE, 16'h7777, 10'd0,    1'b0, '0},
        '{ROW_CFG,  tbps_pkg::OP_TICK,   16'h0000, 10'd10,   1'b0, '0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tbps_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    logic [tbps_pkg::OP_W-1:0]      op;
    logic [tbps_pkg::ID_W-1:0]      packet_id;
    logic [tbps_pkg::TOK_W-1:0]     tokens_needed;
    logic                           out_valid;
    logic                           out_ready;
    logic [tbps_pkg::EV_W-1:0]      event_res;
    logic                           released;
    logic [tbps_pkg::ID_W-1:0]      released_id;
    logic [tbps_pkg::TOK_W-1:0]     tokens_now;
    logic [tbps_pkg::CNT_OUT_W-1:0] queue_count;
    logic [tbps_pkg::CNT_OUT_W-1:0] removed_count;

    // Shaper model state.
    logic [tbps_pkg::TOK_W-1:0] depth_model;
    logic [tbps_pkg::TOK_W-1:0] bucket_model;
    tbps_pkg::entry_t           held_packets[$];

    shaper_res_t pending_results[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          gap_en = 1'b1;
    bit          stall_en = 1'b1;
    int          hold_left = 0;
    int          stall_left = 0;

    token_bucket_packet_shaper #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .packet_id(packet_id), .tokens_needed(tokens_needed),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_res(event_res), .released(released), .released_id(released_id),
        .tokens_now(tokens_now), .queue_count(queue_count), .removed_count(removed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("token_bucket_packet_shaper regression: fail");
            $finish;
        end
    end

    // One event through the bucket and the holding queue.
    function automatic shaper_res_t shape_step(input logic [tbps_pkg::OP_W-1:0] op_i,
                                               input logic [tbps_pkg::ID_W-1:0] id_i,
                                               input logic [tbps_pkg::TOK_W-1:0] need_i);
        shaper_res_t      r;
        tbps_pkg::entry_t slot;
        bit               try_release;
        r = '0;
        try_release = 1'b1;
        if (op_i[1])
        begin
            // Both flush and the spare code clear the queue and skip the release.
            r.removed = tbps_pkg::CNT_OUT_W'(held_packets.size());
            held_packets.delete();
            r.ev = tbps_pkg::EV_FLUSHED;
            try_release = 1'b0;
        end
        else if (op_i == tbps_pkg::OP_TICK)
        begin
            if (bucket_model >= depth_model)
                r.ev = tbps_pkg::EV_TOKEN_DROPPED;
            else
            begin
                bucket_model = bucket_model + 1'b1;
                r.ev = tbps_pkg::EV_TOKEN_ADDED;
            end
        end
        else if (need_i > depth_model)
            r.ev = tbps_pkg::EV_TOO_LARGE;
        else if (held_packets.size() >= QUEUE_DEPTH)
            r.ev = tbps_pkg::EV_QUEUE_FULL;
        else
        begin
            slot.id = id_i;
            slot.need = need_i;
            held_packets.push_back(slot);
            r.ev = tbps_pkg::EV_QUEUED;
        end
        if (try_release && held_packets.size() > 0 && held_packets[0].need <= bucket_model)
        begin
            slot = held_packets.pop_front();
            bucket_model = bucket_model - slot.need;
            r.rel = 1'b1;
            r.rel_id = slot.id;
        end
        r.tokens = bucket_model;
        r.qcount = tbps_pkg::CNT_OUT_W'(held_packets.size());
        return r;
    endfunction

    // Result side: random stall bursts, plus a long hold-off when requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && stall_left == 0 && stall_en && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        shaper_res_t got;
        shaper_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{event_res, released, released_id, tokens_now, queue_count, removed_count};
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result beat ev=%0d rel=%0d id=%h", $realtime,
                             got.ev, got.rel, got.rel_id);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ev !== want.ev || got.rel !== want.rel || got.rel_id !== want.rel_id ||
                    got.tokens !== want.tokens || got.qcount !== want.qcount ||
                    got.removed !== want.removed)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $write("%0t: expected ev=%0d rel=%0d id=%h tok=%0d q=%0d rm=%0d, ",
                               $realtime, want.ev, want.rel, want.rel_id, want.tokens,
                               want.qcount, want.removed);
                        $display("got ev=%0d rel=%0d id=%h tok=%0d q=%0d rm=%0d",
                                 got.ev, got.rel, got.rel_id, got.tokens, got.qcount,
                                 got.removed);
                    end
                end
            end
        end
    end

    // Offers one event, with an optional gap first, and predicts it on acceptance.
    task automatic send_event(input logic [tbps_pkg::OP_W-1:0] op_i,
                              input logic [tbps_pkg::ID_W-1:0] id_i,
                              input logic [tbps_pkg::TOK_W-1:0] need_i, input bit typed,
                              input shaper_res_t typed_res);
        int          gap;
        shaper_res_t predicted;
        gap = (gap_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_i;
        packet_id <= id_i;
        tokens_needed <= need_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = shape_step(op_i, id_i, need_i);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_depth(input logic [tbps_pkg::TOK_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tbps_pkg::ADDR_BUCKET_DEPTH;
        pwdata <= {{(32 - tbps_pkg::TOK_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        depth_model = value;
        // The address still points at the register, so the read data shows the new depth.
        @(posedge clk);
        if (prdata !== {{(32 - tbps_pkg::TOK_W){1'b0}}, value} || pready !== 1'b1)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
                $display("%0t: expected depth readback %0d, got %0d", $realtime, value,
                         prdata);
        end
    endtask

    // One random phase at a fixed depth. A fill run of oversized-but-legal packets up
    // front overflows the queue; hold loads the result side's hold-off counter, with out_ready low.
    task automatic run_phase(input logic [tbps_pkg::TOK_W-1:0] depth, input int beats,
                             input bit gaps, input bit stalls, input bit fill_first,
                             input int hold);
        logic [tbps_pkg::OP_W-1:0]  op_r;
        logic [tbps_pkg::TOK_W-1:0] need_r;
        int                         pick;
        int                         need_cap;
        wait_drained();
        write_depth(depth);
        gap_en = gaps;
        stall_en = stalls;
        if (!stalls)
            stall_left = 0;
        hold_left = hold;
        need_cap = (depth < 12) ? depth : 12;
        for (int i = 0; i < beats; i++)
        begin
            pick = $urandom_range(0, 99);
            if (fill_first && i < 70)
                op_r = tbps_pkg::OP_ARRIVE;
            else if (pick < 45)
                op_r = tbps_pkg::OP_TICK;
            else if (pick < 93)
                op_r = tbps_pkg::OP_ARRIVE;
            else if (pick < 97)
                op_r = tbps_pkg::OP_FLUSH;
            else
                op_r = OP_SPARE;
            if (fill_first && i < 70)
                need_r = depth;
            else if ($urandom_range(0, 3) == 0)
                need_r = tbps_pkg::TOK_W'($urandom_range(0, 1023));
            else
                need_r = tbps_pkg::TOK_W'($urandom_range(0, need_cap));
            send_event(op_r, tbps_pkg::ID_W'($urandom_range(0, 65535)), need_r, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = tbps_pkg::OP_TICK;
        packet_id = '0;
        tokens_needed = '0;
        depth_model = tbps_pkg::BUCKET_DEPTH_RST;
        bucket_model = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_STEPS[i])
        begin
            if (DIRECTED_STEPS[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_depth(DIRECTED_STEPS[i].need);
            end
            else
                send_event(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].id, DIRECTED_STEPS[i].need,
                           DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].res);
        end

        run_phase(10'd1023, 85, 1'b1, 1'b1, 1'b1, 0);
        run_phase(10'd1, 85, 1'b1, 1'b0, 1'b0, 400);
        run_phase(10'($urandom_range(2, 30)), 100, 1'b0, 1'b1, 1'b0, 0);
        run_phase(10'd0, 60, 1'b1, 1'b1, 1'b0, 0);
        run_phase(10'($urandom_range(1, 1023)), 100, 1'b1, 1'b1, 1'b0, 0);
        run_phase(tbps_pkg::BUCKET_DEPTH_RST, 100, 1'b1, 1'b1, 1'b0, 0);
        run_phase(10'($urandom_range(2, 40)), 100, 1'b1, 1'b1, 1'b0, 0);
        run_phase(10'd1023, 80, 1'b0, 1'b0, 1'b0, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("token_bucket_packet_shaper regression: pass");
        else
            $display("token_bucket_packet_shaper regression: fail");
        $finish;
    end

endmodule

// File: token_bucket_packet_shaper.f
src/tbps_pkg.sv
src/token_bucket_packet_shaper.sv
test/token_bucket_packet_shaper_test.sv
